>>> rtl/csel_pkg.sv
// shared types, codes and helpers of the cell selection scanner
package csel_pkg;

  localparam int CNT_W  = 7;
  localparam int ID_W   = 16;
  localparam int MCC_W  = 10;
  localparam int MNC_W  = 10;
  localparam int TAC_W  = 24;
  localparam int NCI_W  = 36;
  localparam int DBM_W  = 9;
  localparam int CFG_W  = 10;
  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

  typedef enum logic [1:0] {
    CMD_ADD_FTAI = 2'd0,
    CMD_CLR_FTAI = 2'd1,
    CMD_CELL     = 2'd2,
    CMD_END_SCAN = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_PLMN_VALID   = 2'd0,
    CFG_SEL_MCC      = 2'd1,
    CFG_SEL_MNC      = 2'd2,
    CFG_SEL_LONG_MNC = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CAT_NONE       = 2'd0,
    CAT_SUITABLE   = 2'd1,
    CAT_ACCEPTABLE = 2'd2
  } cat_t;

  typedef struct packed {
    logic [MCC_W-1:0] mcc;
    logic [MNC_W-1:0] mnc;
    logic             long_mnc;
    logic [TAC_W-1:0] tac;
  } tai_t;

  typedef struct packed {
    logic                    valid;
    logic                    match;
    logic [ID_W-1:0]         id;
    tai_t                    tai;
    logic [NCI_W-1:0]        nci;
    logic signed [DBM_W-1:0] dbm;
  } cand_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [ID_W-1:0]         id;
    tai_t                    tai;
    logic [NCI_W-1:0]        nci;
    logic signed [DBM_W-1:0] dbm;
    logic                    si;
    logic                    barred;
    logic                    reserved;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] si;
    logic [CNT_W-1:0] plmn;
    logic [CNT_W-1:0] bar;
    logic [CNT_W-1:0] res;
    logic [CNT_W-1:0] ftai;
  } rej_cnt_t;

  typedef struct packed {
    logic add;
    logic clr;
  } ftai_ctl_t;

  typedef struct packed {
    logic scan_cell;
    logic clear;
  } trk_ctl_t;

  typedef struct packed {
    cand_t    suit;
    cand_t    acc;
    rej_cnt_t suit_cnt;
    rej_cnt_t acc_cnt;
  } scan_sum_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage

>>> rtl/csel_ftai_table.sv
// forbidden tracking area table with parallel lookup
module csel_ftai_table #(
  parameter int FORBIDDEN_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  csel_pkg::ftai_ctl_t ctl,
  input  csel_pkg::tai_t     tai,
  output logic               hit
);

  localparam int UW = $clog2(FORBIDDEN_DEPTH + 1);
  localparam int IW = (FORBIDDEN_DEPTH > 1) ? $clog2(FORBIDDEN_DEPTH) : 1;

  csel_pkg::tai_t       tbl_r [FORBIDDEN_DEPTH];
  logic [UW-1:0]        used_r, used_nxt;
  logic [FORBIDDEN_DEPTH-1:0] hit_vec;
  logic                 room;

  assign room = (used_r < UW'(FORBIDDEN_DEPTH));

  // only filled entries take part
  for (genvar g = 0; g < FORBIDDEN_DEPTH; g++) begin : g_cmp
    assign hit_vec[g] = (UW'(g) < used_r) && (tbl_r[g] == tai);
  end
  assign hit = |hit_vec;

  always_comb begin
    used_nxt = used_r;
    if (ctl.clr) begin
      used_nxt = '0;
    end else if (ctl.add && room) begin
      used_nxt = used_r + UW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.add && room) begin
      tbl_r[used_r[IW-1:0]] <= tai;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(FORBIDDEN_DEPTH))
    else $error("forbidden table fill beyond depth");

endmodule

>>> rtl/csel_tracker.sv
// running best suitable and acceptable cells and reject counters of one scan
module csel_tracker #(
  parameter int MAX_CELLS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csel_pkg::trk_ctl_t   ctl,
  input  csel_pkg::item_t      item,
  input  logic                 plmn_valid,
  input  logic                 match,
  input  logic                 forb,
  output csel_pkg::scan_sum_t  sum
);

  localparam int SCW = $clog2(MAX_CELLS + 1);

  logic [SCW-1:0]     ncell_r, ncell_nxt;
  csel_pkg::cand_t    suit_r, suit_nxt;
  csel_pkg::cand_t    acc_r, acc_nxt;
  csel_pkg::rej_cnt_t scnt_r, scnt_nxt;
  csel_pkg::rej_cnt_t acnt_r, acnt_nxt;
  csel_pkg::cand_t    cur;
  logic               take;
  logic               suit_better;
  logic               acc_better;

  always_comb begin
    cur       = '0;
    cur.valid = 1'b1;
    cur.match = match;
    cur.id    = item.id;
    cur.tai   = item.tai;
    cur.nci   = item.nci;
    cur.dbm   = item.dbm;
  end

  assign take = ctl.scan_cell && (ncell_r < SCW'(MAX_CELLS));

  // stronger wins, smaller id on equal signal
  assign suit_better = !suit_r.valid ||
                       ($signed(item.dbm) > $signed(suit_r.dbm)) ||
                       (($signed(item.dbm) == $signed(suit_r.dbm)) && (item.id < suit_r.id));

  // plmn match first, then signal, then larger nci
  always_comb begin
    priority if (!acc_r.valid) begin
      acc_better = 1'b1;
    end else if (match != acc_r.match) begin
      acc_better = match;
    end else if ($signed(item.dbm) != $signed(acc_r.dbm)) begin
      acc_better = $signed(item.dbm) > $signed(acc_r.dbm);
    end else begin
      acc_better = item.nci > acc_r.nci;
    end
  end

  always_comb begin
    ncell_nxt = ncell_r;
    suit_nxt  = suit_r;
    acc_nxt   = acc_r;
    scnt_nxt  = scnt_r;
    acnt_nxt  = acnt_r;
    if (ctl.clear) begin
      ncell_nxt = '0;
      suit_nxt  = '0;
      acc_nxt   = '0;
      scnt_nxt  = '0;
      acnt_nxt  = '0;
    end else if (take) begin
      ncell_nxt = ncell_r + SCW'(1);
      if (plmn_valid) begin
        priority if (!item.si) begin
          scnt_nxt.si = csel_pkg::sat_inc(scnt_r.si);
        end else if (!match) begin
          scnt_nxt.plmn = csel_pkg::sat_inc(scnt_r.plmn);
        end else if (item.barred) begin
          scnt_nxt.bar = csel_pkg::sat_inc(scnt_r.bar);
        end else if (item.reserved) begin
          scnt_nxt.res = csel_pkg::sat_inc(scnt_r.res);
        end else if (forb) begin
          scnt_nxt.ftai = csel_pkg::sat_inc(scnt_r.ftai);
        end else if (suit_better) begin
          suit_nxt = cur;
        end
      end
      priority if (!item.si) begin
        acnt_nxt.si = csel_pkg::sat_inc(acnt_r.si);
      end else if (item.barred) begin
        acnt_nxt.bar = csel_pkg::sat_inc(acnt_r.bar);
      end else if (item.reserved) begin
        acnt_nxt.res = csel_pkg::sat_inc(acnt_r.res);
      end else if (forb) begin
        acnt_nxt.ftai = csel_pkg::sat_inc(acnt_r.ftai);
      end else if (acc_better) begin
        acc_nxt = cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncell_r <= '0;
      suit_r  <= '0;
      acc_r   <= '0;
      scnt_r  <= '0;
      acnt_r  <= '0;
    end else begin
      ncell_r <= ncell_nxt;
      suit_r  <= suit_nxt;
      acc_r   <= acc_nxt;
      scnt_r  <= scnt_nxt;
      acnt_r  <= acnt_nxt;
    end
  end

  assign sum.suit     = suit_r;
  assign sum.acc      = acc_r;
  assign sum.suit_cnt = scnt_r;
  assign sum.acc_cnt  = acnt_r;

  a_suit_match: assert property (@(posedge clk) disable iff (!rst_n)
    suit_r.valid |-> suit_r.match)
    else $error("suitable cell kept without plmn match");

  a_ncell_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ncell_r <= SCW'(MAX_CELLS))
    else $error("scan cell count beyond limit");

endmodule

>>> rtl/cell_selection_scanner_unit.sv
// top level of the cell selection scanner: request register, table, tracker, result register
//
// Scans cell descriptions one request at a time. A request carries one command: add a
// forbidden tracking area, clear the forbidden table, describe a cell, or end the scan.
// Each cell is checked for system info, barring, reservation and a forbidden tracking
// area, once against the selected PLMN (suitable) and once without it (acceptable),
// and the best of each kind is kept. Ending a scan emits one result with the chosen
// cell, its category, the reject counters of the pass used and whether the chosen id
// changed since the last scan; the other commands emit nothing. Rate: one request per
// clock, sustained. A request is registered on acceptance and is fully processed in the
// next cycle (parallel compare against every forbidden entry plus one running-best
// update), so out_valid rises at the clock edge right after the one that took its
// end-of-scan request. in_stall rises only while an end-of-scan request waits behind a
// result that the sink has not taken yet. Configuration is sampled per cell; write it
// while idle.
module cell_selection_scanner_unit #(
  parameter int FORBIDDEN_DEPTH = 16,
  parameter int MAX_CELLS       = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_cell_id,
  input  logic [9:0]  in_mcc,
  input  logic [9:0]  in_mnc,
  input  logic        in_long_mnc,
  input  logic [23:0] in_tac,
  input  logic [35:0] in_nci,
  input  logic signed [8:0] in_signal_dbm,
  input  logic        in_si_present,
  input  logic        in_barred,
  input  logic        in_reserved,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_selected_cell,
  output logic [1:0]  out_category,
  output logic [9:0]  out_mcc,
  output logic [9:0]  out_mnc,
  output logic        out_long_mnc,
  output logic [23:0] out_tac,
  output logic        out_cell_changed,
  output logic [6:0]  out_si_missing_count,
  output logic [6:0]  out_out_of_plmn_count,
  output logic [6:0]  out_barred_count,
  output logic [6:0]  out_reserved_count,
  output logic [6:0]  out_forbidden_count
);

  // configuration registers
  logic                           plmn_valid_r;
  logic [csel_pkg::MCC_W-1:0]     sel_mcc_r;
  logic [csel_pkg::MNC_W-1:0]     sel_mnc_r;
  logic                           sel_long_mnc_r;

  // request stage
  logic                 s1_v_r, s1_v_nxt;
  csel_pkg::item_t      s1_r;
  csel_pkg::item_t      in_item;
  logic                 in_take;
  logic                 s1_end;
  logic                 s1_go;

  // sub-block links
  csel_pkg::ftai_ctl_t  ftai_ctl;
  csel_pkg::trk_ctl_t   trk_ctl;
  csel_pkg::scan_sum_t  sum;
  logic                 forb;
  logic                 match;

  // result selection
  logic                 use_suit;
  csel_pkg::cand_t      ch;
  csel_pkg::cat_t       cat;
  csel_pkg::rej_cnt_t   cnt;
  logic                 emit;

  // result register and last reported id
  logic                        out_valid_r, out_valid_nxt;
  logic [csel_pkg::ID_W-1:0]   sel_cell_r;
  csel_pkg::cat_t              cat_r;
  csel_pkg::tai_t              tai_out_r;
  logic                        changed_r;
  csel_pkg::rej_cnt_t          cnt_out_r;
  logic [csel_pkg::ID_W-1:0]   last_sel_r;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plmn_valid_r   <= 1'b0;
      sel_mcc_r      <= '0;
      sel_mnc_r      <= '0;
      sel_long_mnc_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (csel_pkg::cfg_idx_t'(cfg_index))
        csel_pkg::CFG_PLMN_VALID:   plmn_valid_r   <= cfg_wdata[0];
        csel_pkg::CFG_SEL_MCC:      sel_mcc_r      <= cfg_wdata[csel_pkg::MCC_W-1:0];
        csel_pkg::CFG_SEL_MNC:      sel_mnc_r      <= cfg_wdata[csel_pkg::MNC_W-1:0];
        csel_pkg::CFG_SEL_LONG_MNC: sel_long_mnc_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // request register
  // ---------------------------------------------------------------------------
  always_comb begin
    in_item.cmd          = csel_pkg::cmd_t'(in_command);
    in_item.id           = in_cell_id;
    in_item.tai.mcc      = in_mcc;
    in_item.tai.mnc      = in_mnc;
    in_item.tai.long_mnc = in_long_mnc;
    in_item.tai.tac      = in_tac;
    in_item.nci          = in_nci;
    in_item.dbm          = in_signal_dbm;
    in_item.si           = in_si_present;
    in_item.barred       = in_barred;
    in_item.reserved     = in_reserved;
  end

  assign s1_end   = (s1_r.cmd == csel_pkg::CMD_END_SCAN);
  // only an end-of-scan needs room in the result register
  assign in_stall = s1_v_r && s1_end && out_valid_r && out_stall;
  assign s1_go    = s1_v_r && !in_stall;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_take) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= in_item;
    end
  end

  // ---------------------------------------------------------------------------
  // processing of the registered request
  // ---------------------------------------------------------------------------
  assign ftai_ctl.add      = s1_go && (s1_r.cmd == csel_pkg::CMD_ADD_FTAI);
  assign ftai_ctl.clr      = s1_go && (s1_r.cmd == csel_pkg::CMD_CLR_FTAI);
  assign trk_ctl.scan_cell = s1_go && (s1_r.cmd == csel_pkg::CMD_CELL);
  assign trk_ctl.clear     = s1_go && s1_end;
  assign emit              = trk_ctl.clear;

  // plmn equality needs country code, network code and its length
  assign match = plmn_valid_r && (s1_r.tai.mcc == sel_mcc_r) &&
                 (s1_r.tai.mnc == sel_mnc_r) && (s1_r.tai.long_mnc == sel_long_mnc_r);

  csel_ftai_table #(
    .FORBIDDEN_DEPTH (FORBIDDEN_DEPTH)
  ) u_ftai (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ftai_ctl),
    .tai   (s1_r.tai),
    .hit   (forb)
  );

  csel_tracker #(
    .MAX_CELLS (MAX_CELLS)
  ) u_trk (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (trk_ctl),
    .item       (s1_r),
    .plmn_valid (plmn_valid_r),
    .match      (match),
    .forb       (forb),
    .sum        (sum)
  );

  // ---------------------------------------------------------------------------
  // end-of-scan choice: suitable if any, else best acceptable, else nothing
  // ---------------------------------------------------------------------------
  assign use_suit = plmn_valid_r && sum.suit.valid;

  always_comb begin
    ch  = '0;
    cat = csel_pkg::CAT_NONE;
    cnt = sum.acc_cnt;
    cnt.plmn = '0;
    if (use_suit) begin
      ch  = sum.suit;
      cat = csel_pkg::CAT_SUITABLE;
      cnt = sum.suit_cnt;
    end else if (sum.acc.valid) begin
      ch  = sum.acc;
      cat = csel_pkg::CAT_ACCEPTABLE;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_sel_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        last_sel_r <= ch.id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sel_cell_r <= ch.id;
      cat_r      <= cat;
      tai_out_r  <= ch.tai;
      changed_r  <= (ch.id != last_sel_r);
      cnt_out_r  <= cnt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_selected_cell     = sel_cell_r;
  assign out_category          = cat_r;
  assign out_mcc               = tai_out_r.mcc;
  assign out_mnc               = tai_out_r.mnc;
  assign out_long_mnc          = tai_out_r.long_mnc;
  assign out_tac               = tai_out_r.tac;
  assign out_cell_changed      = changed_r;
  assign out_si_missing_count  = cnt_out_r.si;
  assign out_out_of_plmn_count = cnt_out_r.plmn;
  assign out_barred_count      = cnt_out_r.bar;
  assign out_reserved_count    = cnt_out_r.res;
  assign out_forbidden_count   = cnt_out_r.ftai;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s1_end && out_valid_r))
    else $error("request stalled without a pending end of scan");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_v_r && s1_end))
    else $error("result appeared without an end of scan request");

  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (cat_r == csel_pkg::CAT_NONE)) |->
      ((sel_cell_r == '0) && (cnt_out_r.plmn == '0) && (tai_out_r == '0)))
    else $error("empty result carries cell data");

endmodule
